FILE: rtl/core/bda_pkg.sv
// shared types and constants for the button debounce with auto-repeat
package bda_pkg;

    // phase codes
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_PRESSING   = 3'd1;
    localparam logic [2:0] PH_PRESSED    = 3'd2;
    localparam logic [2:0] PH_AUTOREPEAT = 3'd3;
    localparam logic [2:0] PH_RELEASING  = 3'd4;

    // register indexes
    localparam logic REG_HOLD_DELAY   = 1'b0;
    localparam logic REG_REPEAT_START = 1'b1;

    // register reset values
    localparam logic [15:0] HOLD_DELAY_RESET   = 16'd200;
    localparam logic [9:0]  REPEAT_START_RESET = 10'd20;

    // configuration seen by the step logic
    typedef struct packed {
        logic [15:0] hold_delay;
        logic [9:0]  repeat_start;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic       key_event;
        logic [2:0] debounce_state;
    } res_t;

endpackage

FILE: rtl/core/bda_cfg.sv
// apb register bank holding hold_delay and repeat_start
module bda_cfg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output bda_pkg::cfg_t     cfg
);

    logic        wr_en;
    logic        reg_idx;
    logic [15:0] hold_delay_reg;
    logic [9:0]  repeat_start_reg;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_delay_reg   <= bda_pkg::HOLD_DELAY_RESET;
            repeat_start_reg <= bda_pkg::REPEAT_START_RESET;
        end
        else if (wr_en)
        begin
            if (reg_idx == bda_pkg::REG_HOLD_DELAY)
            begin
                hold_delay_reg <= pwdata[15:0];
            end
            else
            begin
                repeat_start_reg <= pwdata[9:0];
            end
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            bda_pkg::REG_HOLD_DELAY:   prdata = {16'd0, hold_delay_reg};
            bda_pkg::REG_REPEAT_START: prdata = {22'd0, repeat_start_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    assign cfg.hold_delay   = hold_delay_reg;
    assign cfg.repeat_start = repeat_start_reg;

endmodule

FILE: rtl/core/bda_step.sv
// debounce and auto-repeat state machine, one tick per enabled cycle
module bda_step
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  logic          btn,
    input  bda_pkg::cfg_t cfg,
    output bda_pkg::res_t res
);

    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic [15:0] hold_count_reg;
    logic [15:0] hold_count_next;
    logic [9:0]  repeat_count_reg;
    logic [9:0]  repeat_count_next;
    logic [9:0]  repeat_interval_reg;
    logic [9:0]  repeat_interval_next;
    logic [9:0]  interval_dec;
    logic        ev;

    // next interval after an auto-repeat event, floor of one
    assign interval_dec = (repeat_interval_reg > 10'd1) ?
                          (repeat_interval_reg - 10'd1) : repeat_interval_reg;

    // next state for one tick
    always_comb
    begin
        phase_next           = phase_reg;
        hold_count_next      = hold_count_reg;
        repeat_count_next    = repeat_count_reg;
        repeat_interval_next = repeat_interval_reg;
        ev                   = 1'b0;
        unique case (phase_reg)
            bda_pkg::PH_IDLE:
            begin
                if (btn)
                begin
                    phase_next = bda_pkg::PH_PRESSING;
                end
            end
            bda_pkg::PH_PRESSING:
            begin
                if (btn)
                begin
                    ev              = 1'b1;
                    hold_count_next = cfg.hold_delay;
                    phase_next      = bda_pkg::PH_PRESSED;
                end
                else
                begin
                    phase_next = bda_pkg::PH_IDLE;
                end
            end
            bda_pkg::PH_PRESSED:
            begin
                if (!btn)
                begin
                    phase_next = bda_pkg::PH_RELEASING;
                end
                if (hold_count_reg != 16'd0)
                begin
                    hold_count_next = hold_count_reg - 16'd1;
                    // hold delay expired, start auto-repeat even on release
                    if (hold_count_reg == 16'd1)
                    begin
                        repeat_count_next    = cfg.repeat_start;
                        repeat_interval_next = cfg.repeat_start;
                        phase_next           = bda_pkg::PH_AUTOREPEAT;
                    end
                end
            end
            bda_pkg::PH_AUTOREPEAT:
            begin
                if (!btn)
                begin
                    phase_next = bda_pkg::PH_RELEASING;
                end
                if (repeat_count_reg != 10'd0)
                begin
                    repeat_count_next = repeat_count_reg - 10'd1;
                    if (repeat_count_reg == 10'd1)
                    begin
                        ev                   = 1'b1;
                        repeat_interval_next = interval_dec;
                        repeat_count_next    = interval_dec;
                    end
                end
            end
            bda_pkg::PH_RELEASING:
            begin
                // back to pressed keeps the hold count as it is
                phase_next = btn ? bda_pkg::PH_PRESSED : bda_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = bda_pkg::PH_IDLE;
            end
        endcase
    end

    // state update on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= bda_pkg::PH_IDLE;
            hold_count_reg      <= 16'd0;
            repeat_count_reg    <= 10'd0;
            repeat_interval_reg <= 10'd0;
        end
        else if (step_en)
        begin
            phase_reg           <= phase_next;
            hold_count_reg      <= hold_count_next;
            repeat_count_reg    <= repeat_count_next;
            repeat_interval_reg <= repeat_interval_next;
        end
    end

    assign res.key_event      = ev;
    assign res.debounce_state = phase_next;

endmodule

FILE: rtl/core/button_debounce_autorepeat.sv
// top level: button debounce with accelerating auto-repeat
// Each input transfer is one scan tick carrying the raw button level, and each tick gives
// exactly one result transfer with the key event flag and the debounce phase after the tick.
// A tick is accepted every clock while the result register is free or being drained, and its
// result appears in the next cycle from that single result register; throughput is one tick
// per cycle, set by the debounce state machine update. The user must write hold_delay (address 0)
// and repeat_start (address 4) over the APB port only while no tick is in flight (not enforced).
module button_debounce_autorepeat
(
    input  logic        clk,
    input  logic        rst_n,
    // tick input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        pressed,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        key_event,
    output logic [2:0]  debounce_state,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bda_pkg::cfg_t cfg;
    bda_pkg::res_t res;
    logic          in_xfer;
    logic          out_valid_reg;
    logic          key_event_reg;
    logic [2:0]    debounce_state_reg;

    bda_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bda_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (in_xfer),
        .btn     (pressed),
        .cfg     (cfg),
        .res     (res)
    );

    // accept while the result register is empty or drains this cycle
    assign in_stall = out_valid_reg & out_stall;
    assign in_xfer  = in_valid & ~in_stall;

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            key_event_reg      <= res.key_event;
            debounce_state_reg <= res.debounce_state;
        end
    end

    assign out_valid      = out_valid_reg;
    assign key_event      = key_event_reg;
    assign debounce_state = debounce_state_reg;

    // a key event never comes with idle or pressing phase
    a_event_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && key_event) |->
        (debounce_state == bda_pkg::PH_PRESSED || debounce_state == bda_pkg::PH_AUTOREPEAT ||
         debounce_state == bda_pkg::PH_RELEASING))
        else $error("key event with idle or pressing phase");

    // input is held back only by a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a pending result");

    // every accepted tick shows up in the result register
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted tick produced no result");

endmodule

FILE: tb/button_debounce_autorepeat_tb.sv
// testbench for the button debounce with auto-repeat: scan-tick stimulus, prediction and checks
`timescale 1ns / 100ps

// tracks the debounce phase per tick and checks each result transfer against it
class debounce_scoreboard;
    logic [15:0]     hold_delay;
    logic [9:0]      repeat_start;
    logic [2:0]      phase;
    logic [15:0]     hold_count;
    logic [9:0]      repeat_count;
    logic [9:0]      repeat_interval;
    bda_pkg::res_t   expected_results[$];
    int              errors;

    function new();
        hold_delay      = bda_pkg::HOLD_DELAY_RESET;
        repeat_start    = bda_pkg::REPEAT_START_RESET;
        phase           = bda_pkg::PH_IDLE;
        hold_count      = '0;
        repeat_count    = '0;
        repeat_interval = '0;
        errors          = 0;
    endfunction

    // mirror of a register write
    function void set_register(logic idx, logic [31:0] value);
        if (idx == bda_pkg::REG_HOLD_DELAY)
            hold_delay = value[15:0];
        else
            repeat_start = value[9:0];
    endfunction

    // advance the debounce phase by one accepted tick and queue its result
    function void note_tick(logic level);
        bda_pkg::res_t r;
        r.key_event = 1'b0;
        case (phase)
            bda_pkg::PH_IDLE:
            begin
                if (level)
                    phase = bda_pkg::PH_PRESSING;
            end
            bda_pkg::PH_PRESSING:
            begin
                if (level)
                begin
                    r.key_event = 1'b1;
                    hold_count  = hold_delay;
                    phase       = bda_pkg::PH_PRESSED;
                end
                else
                    phase = bda_pkg::PH_IDLE;
            end
            bda_pkg::PH_PRESSED:
            begin
                if (!level)
                    phase = bda_pkg::PH_RELEASING;
                // hold expiry wins over a release on the same tick
                if (hold_count != 0)
                begin
                    hold_count = hold_count - 1'b1;
                    if (hold_count == 0)
                    begin
                        repeat_count    = repeat_start;
                        repeat_interval = repeat_start;
                        phase           = bda_pkg::PH_AUTOREPEAT;
                    end
                end
            end
            bda_pkg::PH_AUTOREPEAT:
            begin
                if (!level)
                    phase = bda_pkg::PH_RELEASING;
                if (repeat_count != 0)
                begin
                    repeat_count = repeat_count - 1'b1;
                    if (repeat_count == 0)
                    begin
                        r.key_event = 1'b1;
                        // interval shrinks per event, floor of one tick
                        if (repeat_interval > 1)
                            repeat_interval = repeat_interval - 1'b1;
                        repeat_count = repeat_interval;
                    end
                end
            end
            bda_pkg::PH_RELEASING:
            begin
                // back to pressed keeps the old hold count
                phase = level ? bda_pkg::PH_PRESSED : bda_pkg::PH_IDLE;
            end
            default:
                phase = bda_pkg::PH_IDLE;
        endcase
        r.debounce_state = phase;
        expected_results.push_back(r);
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(logic key_event, logic [2:0] debounce_state);
        bda_pkg::res_t exp_r;
        if (expected_results.size() == 0)
        begin
            $display("%0t: unexpected result key_event=%0d debounce_state=%0d",
                     $time, key_event, debounce_state);
            errors++;
            return;
        end
        exp_r = expected_results.pop_front();
        if (key_event !== exp_r.key_event)
        begin
            $display("%0t: key_event expected %0d actual %0d",
                     $time, exp_r.key_event, key_event);
            errors++;
        end
        if (debounce_state !== exp_r.debounce_state)
        begin
            $display("%0t: debounce_state expected %0d actual %0d",
                     $time, exp_r.debounce_state, debounce_state);
            errors++;
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction
endclass

module button_debounce_autorepeat_tb;

    localparam int TICKS_PER_SETTING = 90;
    localparam int SETTING_COUNT     = 8;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic        pressed   = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        key_event;
    logic [2:0]  debounce_state;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // set while both sides run with no idle cycles
    logic steady = 1'b0;

    debounce_scoreboard sb = new();

    button_debounce_autorepeat uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pressed        (pressed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .key_event      (key_event),
        .debounce_state (debounce_state),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // random back-pressure on the result channel
    always @(negedge clk)
    begin
        out_stall <= !steady && ($urandom_range(99) < 26);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(key_event, debounce_state);
    end

    // one register write: setup cycle then access cycle
    task write_reg(input logic idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_register(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // one scan tick transfer, with random idle cycles before it
    task send_tick(input logic level);
        while (!steady && $urandom_range(99) < 26)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        pressed  = level;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_tick(level);
        @(negedge clk);
    endtask

    // stop sending and wait for every outstanding result
    task drain();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // press and release runs of random length, with single-tick glitches
    task send_button_runs(input int count);
        int   sent;
        int   len;
        logic level;
        sent  = 0;
        level = 1'b1;
        while (sent < count)
        begin
            if ($urandom_range(99) < 20)
                len = 1;
            else if (level && $urandom_range(99) < 8)
                len = $urandom_range(120, 40);
            else if (level)
                len = $urandom_range(40, 2);
            else
                len = $urandom_range(6, 2);
            for (int i = 0; i < len && sent < count; i++)
            begin
                send_tick(level);
                sent++;
            end
            level = !level;
        end
    endtask

    // directed ticks: bounce, hold expiry, shrinking repeat, return from release,
    // hold expiry on the release tick
    task send_directed();
        string pattern;
        pattern = "010111111111110110011011000";
        for (int i = 0; i < pattern.len(); i++)
            send_tick(pattern[i] == "1");
    endtask

    // main sequence
    initial
    begin
        logic [15:0] hold_val;
        logic [9:0]  rep_val;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_reg(bda_pkg::REG_HOLD_DELAY, 32'd3);
        write_reg(bda_pkg::REG_REPEAT_START, 32'd3);
        send_directed();
        drain();

        for (int s = 0; s < SETTING_COUNT; s++)
        begin
            case (s)
                0: begin hold_val = 16'd1;     rep_val = 10'd1;    end
                1: begin hold_val = 16'hFFFF;  rep_val = 10'h3FF;  end
                2: begin hold_val = 16'd4;     rep_val = 10'd3;    end
                3: begin hold_val = 16'd0;     rep_val = 10'd5;    end
                4: begin hold_val = 16'd3;     rep_val = 10'd0;    end
                5:
                begin
                    hold_val = bda_pkg::HOLD_DELAY_RESET;
                    rep_val  = bda_pkg::REPEAT_START_RESET;
                end
                6: begin hold_val = 16'd1;     rep_val = 10'h3FF;  end
                default:
                begin
                    hold_val = 16'($urandom_range(9, 2));
                    rep_val  = 10'($urandom_range(7, 1));
                end
            endcase
            write_reg(bda_pkg::REG_HOLD_DELAY, {16'd0, hold_val});
            write_reg(bda_pkg::REG_REPEAT_START, {22'd0, rep_val});
            steady = (s == 2);
            send_button_runs(TICKS_PER_SETTING);
            drain();
            steady = 1'b0;
        end

        if (sb.errors == 0)
            $display("button_debounce_autorepeat_tb: PASS");
        else
            $display("button_debounce_autorepeat_tb: FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("button_debounce_autorepeat_tb: FAIL");
        $finish;
    end

endmodule
